@@ rtl/twv_pkg.sv @@
// shared types, constants and register codes of the temperature window validator
package twv_pkg;

  localparam int TWV_SENSORS = 4;
  localparam int TWV_WINDOW  = 4;

  localparam int SENSOR_W  = 2;
  localparam int TIME_W    = 16;
  localparam int SAMPLE_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int OUT_W     = 32;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [TIME_W-1:0]   stamp_t;

  localparam logic [CFG_IDX_W-1:0] REG_LO_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HI_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA = 2'd2;

  localparam sample_t LO_LIMIT_RST  = 8'd2;
  localparam sample_t HI_LIMIT_RST  = 8'd120;
  localparam sample_t MAX_DELTA_RST = 8'd10;

  typedef struct packed {
    sample_t lo_limit;
    sample_t hi_limit;
    sample_t max_delta;
  } cfg_t;

  typedef struct packed {
    logic in_range;
    logic changed;
  } lane_flag_t;

endpackage

@@ rtl/temperature_window_validator_core.sv @@
// top level of the temperature window validator: lanes, merge, sensor store, output skid
//
// in_* channel: one item per window, tdata holds sensor, now_time and the
//   samples oldest first; every item gives exactly one result on out_*.
// out_* channel: accepted flag, the sensor's stored temperature and time
//   as they stand after the item.
// cfg_* channel: register index and data, always ready; write only while
//   no item is in flight.
// the result is registered in the output register before it shows on
//   out_tvalid. throughput: one item per cycle while the receiver keeps
//   up, set by the read-modify-write of the per-sensor register store.
// when the receiver stalls, the result holds in the output register and
//   one more item is taken into the skid register; in_tready then drops
//   until the receiver drains it.
// reset: synchronous, active low; clears the stored temperatures and
//   times, restores the register defaults and empties the output side.
module temperature_window_validator_core
  import twv_pkg::*;
#(
  parameter int SENSORS = TWV_SENSORS,
  parameter int WINDOW  = TWV_WINDOW,
  localparam int IN_W   = ((SENSOR_W + TIME_W + SAMPLE_W * WINDOW + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // sensor, now_time, sample_0 .. sample_(WINDOW-1), zero pad
  input  logic [IN_W-1:0]      in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // accepted, valid_temperature, valid_time, zero pad
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int IDX_W    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int SAMP_LSB = SENSOR_W + TIME_W;
  localparam int RES_W    = 1 + SAMPLE_W + TIME_W;

  cfg_t cfg_r;

  sample_t temp_r  [SENSORS];
  stamp_t  stamp_r [SENSORS];

  logic [SENSOR_W-1:0] sensor;
  stamp_t              now_time;
  sample_t             samples [WINDOW];
  lane_flag_t          flags   [WINDOW];
  logic [IDX_W-1:0]    idx;
  logic                sensor_ok;
  sample_t             stored_temp;
  stamp_t              stored_stamp;
  sample_t             newest;
  logic                accept;
  logic [RES_W-1:0]    result;
  logic                in_fire;

  logic             out_v_r;
  logic [RES_W-1:0] out_d_r;
  logic             skid_v_r;
  logic [RES_W-1:0] skid_d_r;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lo_limit  <= LO_LIMIT_RST;
      cfg_r.hi_limit  <= HI_LIMIT_RST;
      cfg_r.max_delta <= MAX_DELTA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LO_LIMIT:  cfg_r.lo_limit  <= cfg_data;
        REG_HI_LIMIT:  cfg_r.hi_limit  <= cfg_data;
        REG_MAX_DELTA: cfg_r.max_delta <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack
  assign sensor   = in_tdata[SENSOR_W-1:0];
  assign now_time = in_tdata[SENSOR_W +: TIME_W];

  generate
    for (genvar g = 0; g < WINDOW; g++) begin : g_lane
      assign samples[g] = in_tdata[SAMP_LSB + g * SAMPLE_W +: SAMPLE_W];
      twv_lane u_lane (
        .sample      (samples[g]),
        .prev_sample ((g == 0) ? samples[0] : samples[(g == 0) ? 0 : g - 1]),
        .cfg         (cfg_r),
        .flag        (flags[g])
      );
    end
  endgenerate

  assign newest    = samples[WINDOW-1];
  assign sensor_ok = 32'(sensor) < 32'(SENSORS);
  assign idx       = IDX_W'(sensor);

  assign stored_temp  = sensor_ok ? temp_r[idx]  : '0;
  assign stored_stamp = sensor_ok ? stamp_r[idx] : '0;

  twv_merge #(.WINDOW(WINDOW)) u_merge (
    .flags     (flags),
    .newest    (newest),
    .stored    (stored_temp),
    .cfg       (cfg_r),
    .sensor_ok (sensor_ok),
    .accept    (accept)
  );

  assign result = accept ? {now_time, newest, 1'b1} : {stored_stamp, stored_temp, 1'b0};

  // per-sensor store
  assign in_tready = !skid_v_r;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSORS; i++) begin
        temp_r[i]  <= '0;
        stamp_r[i] <= '0;
      end
    end else if (in_fire && accept) begin
      temp_r[idx]  <= newest;
      stamp_r[idx] <= now_time;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r  <= skid_v_r || in_fire;
      skid_v_r <= 1'b0;
    end else if (in_fire) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_d_r <= skid_v_r ? skid_d_r : result;
    end else if (in_fire) begin
      skid_d_r <= result;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_W - RES_W){1'b0}}, out_d_r};

endmodule

@@ rtl/twv_lane.sv @@
// one sample lane: plausibility range check and change against the previous sample
module twv_lane
  import twv_pkg::*;
(
  input  sample_t    sample,
  input  sample_t    prev_sample,
  input  cfg_t       cfg,
  output lane_flag_t flag
);

  assign flag.in_range = (sample != '0) && (sample >= cfg.lo_limit) &&
                         (sample <= cfg.hi_limit);
  assign flag.changed  = (sample != prev_sample);

endmodule

@@ rtl/twv_merge.sv @@
// merges the lane flags and checks the newest sample against the stored value
module twv_merge
  import twv_pkg::*;
#(
  parameter int WINDOW = TWV_WINDOW
) (
  input  lane_flag_t flags [WINDOW],
  input  sample_t    newest,
  input  sample_t    stored,
  input  cfg_t       cfg,
  input  logic       sensor_ok,
  output logic       accept
);

  logic    all_in_range;
  logic    any_changed;
  sample_t diff;
  logic    delta_ok;

  always_comb begin
    all_in_range = 1'b1;
    any_changed  = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      all_in_range = all_in_range & flags[i].in_range;
      if (i > 0) begin
        any_changed = any_changed | flags[i].changed;
      end
    end
  end

  assign diff     = (stored > newest) ? (stored - newest) : (newest - stored);
  assign delta_ok = (stored == '0) || (diff < cfg.max_delta);
  assign accept   = sensor_ok && all_in_range && any_changed && delta_ok;

endmodule

@@ rtl/twv_checker.sv @@
// port-level checks of the temperature window validator, bound to the top level
module twv_checker
  import twv_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result shown straight after reset");

  a_acc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[SAMPLE_W:1] != '0)
    else $error("accepted window with zero stored temperature");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !$past(out_tready))
    else $error("input stalled without a waiting result");

endmodule

bind temperature_window_validator_core twv_checker u_twv_checker (.*);
